/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SPQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// antecedent in one cycle implies consequent in the next
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

/* rtl/spq_pkg.sv */
// types, constants and codes of the sorted priority queue
// no dependencies
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic signed [DATA_W-1:0] priority_num;
   } entry_type;

   typedef struct packed {
      op_type    op;
      entry_type new_entry;
   } ctrl_type;

endpackage

/* rtl/spq_cell.sv */
// one slot of the sorted queue: compares with the new entry and shifts
// depends on spq_pkg
module spq_cell (
   input  logic              clock,
   input  spq_pkg::ctrl_type ctrl,
   input  logic              occupied,
   input  spq_pkg::entry_type left_entry,
   input  logic              left_ge,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic              ge
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // held entry ranks behind (or equal to) the incoming one
   assign ge    = occupied &&
                  ($signed(entry_ff.priority_num) >= $signed(ctrl.new_entry.priority_num));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (left_ge) begin
               entry_in = left_entry;
            end else if (ge || !occupied) begin
               entry_in = ctrl.new_entry;
            end
         end
         OP_DELETE: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/sorted_priority_queue.sv */
// top level of the sorted priority queue: count, control and the cell row
// depends on spq_pkg and spq_cell
//
// bounded priority queue held as a row of DEPTH cells in ascending order
// of signed priority number; cell 0 is the front entry
// request channel: a beat is taken at a clock edge with start high and
//   busy low; req_cmd selects insert (element and priority) or delete
// busy is always low: every cell compares against the new priority and
//   shifts toward its neighbor in the same cycle, so one beat per cycle
// response channel: rsp_valid is high for exactly one cycle, the cycle
//   after the request beat (throughput 1 beat per cycle)
// insert places the entry ahead of all held entries of equal or greater
//   priority; a full queue reports overflow and changes nothing
// delete returns the front entry; an empty queue reports underflow with
//   -1 in both data fields; inserts return zero data
// rsp_entry_count is the number held after the beat
// reset clears the count and the response strobe; cell contents are
//   don't-care until written and never read beyond the count
// the receiver cannot stall, so every response beat is taken as shown
module sorted_priority_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic signed [31:0]          req_element_in,
   input  logic signed [31:0]          req_priority_in,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_element_out,
   output logic signed [31:0]          rsp_priority_out,
   output logic [4:0]                  rsp_entry_count
);
   import spq_pkg::*;

   logic                  accept;
   logic                  full;
   logic                  empty;
   ctrl_type              ctrl;

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [1:0]            rsp_status_in;
   entry_type             rsp_entry_ff;
   entry_type             rsp_entry_in;

   // cell row taps
   entry_type             cell_entry [DEPTH];
   logic                  cell_ge    [DEPTH];
   logic                  cell_occ   [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == COUNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   // decode the beat into a row-wide operation
   always_comb begin
      ctrl.op                     = OP_HOLD;
      ctrl.new_entry.element      = req_element_in;
      ctrl.new_entry.priority_num = req_priority_in;
      if (accept) begin
         if (req_cmd == CMD_INSERT && !full) begin
            ctrl.op = OP_INSERT;
         end else if (req_cmd == CMD_DELETE && !empty) begin
            ctrl.op = OP_DELETE;
         end
      end
   end

   // the row: each cell sees its left and right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_ge;

      assign cell_occ[i] = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_first
         assign left_entry = ctrl.new_entry;
         assign left_ge    = 1'b0;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (cell_occ[i]),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   // count and response beat
   always_comb begin
      count_in                    = count_ff;
      rsp_status_in               = ST_OK;
      rsp_entry_in.element        = '0;
      rsp_entry_in.priority_num   = '0;
      case (ctrl.op)
         OP_INSERT: begin
            count_in = count_ff + COUNT_W'(1);
         end
         OP_DELETE: begin
            count_in     = count_ff - COUNT_W'(1);
            rsp_entry_in = cell_entry[0];
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      // rejected beats
      if (accept && req_cmd == CMD_INSERT && full) begin
         rsp_status_in = ST_OVERFLOW;
      end
      if (accept && req_cmd == CMD_DELETE && empty) begin
         rsp_status_in             = ST_UNDERFLOW;
         rsp_entry_in.element      = '1;
         rsp_entry_in.priority_num = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_element_out  = rsp_entry_ff.element;
   assign rsp_priority_out = rsp_entry_ff.priority_num;
   assign rsp_entry_count  = 5'(count_ff);

endmodule

/* rtl/spq_checker.sv */
// port-level checks of the sorted priority queue, bound to the top level
// depends on spq_pkg and assert_macros.svh
`include "assert_macros.svh"

module spq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_element_out,
   input logic signed [31:0] rsp_priority_out,
   input logic [4:0]         rsp_entry_count
);
   import spq_pkg::*;

   // every request beat gets exactly one response in the next cycle
   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_valid)
   `SPQ_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), !rsp_valid)

   // underflow returns all ones in both data fields
   `SPQ_ASSERT(a_underflow_data, clock, reset,
      rsp_valid && rsp_status == ST_UNDERFLOW |->
         rsp_element_out == -32'sd1 && rsp_priority_out == -32'sd1)

   // overflow only on insert, underflow only on delete
   `SPQ_ASSERT(a_status_cmd, clock, reset,
      rsp_valid && rsp_status != ST_OK |->
         ($past(req_cmd) == CMD_INSERT && rsp_status == ST_OVERFLOW) ||
         ($past(req_cmd) == CMD_DELETE && rsp_status == ST_UNDERFLOW))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

/* verif/testbench.sv */
// self-checking testbench for the sorted priority queue
// depends on spq_pkg and the sorted_priority_queue rtl; reads no files
// directed and random insert/delete beats are checked against a sorted-row predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // slowest correct run: about 1600 beats with random idle runs, plus
   // drains; this is many times that
   localparam int RUN_LIMIT   = 200_000;
   localparam int TAIL_CYCLES = 8;

   // one response beat as the queue reports it
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic signed [31:0] prio;
      logic [4:0]         count;
   } queue_result_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               req_cmd         = CMD_INSERT;
   logic signed [31:0] req_element_in  = '0;
   logic signed [31:0] req_priority_in = '0;
   logic               busy;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_element_out;
   logic signed [31:0] rsp_priority_out;
   logic [4:0]         rsp_entry_count;

   sorted_priority_queue uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_element_in   (req_element_in),
      .req_priority_in  (req_priority_in),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_element_out  (rsp_element_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predicted queue contents: slot 0 is the front, ascending priority
   logic signed [31:0] held_elem [DEPTH];
   logic signed [31:0] held_prio [DEPTH];
   int                 held_count = 0;

   // responses still owed by the block, oldest first
   queue_result_type pending_results[$];

   // percentage of cycles in which the sender holds start low
   int idle_pct = 0;

   int errors       = 0;
   int cycle_count  = 0;
   int n_checked    = 0;
   int n_insert     = 0;
   int n_delete     = 0;
   int n_overflow   = 0;
   int n_underflow  = 0;
   int peak_count   = 0;

   // apply one accepted beat to the predicted queue and return its response
   function automatic queue_result_type apply_queue_beat(input logic cmd,
                                                         input logic signed [31:0] elem,
                                                         input logic signed [31:0] prio);
      queue_result_type r;
      int pos;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_INSERT) begin
         n_insert++;
         if (held_count >= DEPTH) begin
            // full: reported, nothing moves
            r.status = ST_OVERFLOW;
            n_overflow++;
         end else begin
            // walk from the rear, shifting every entry of equal or greater
            // priority back one slot so the newest leads among equals
            pos = held_count;
            while (pos > 0 && held_prio[pos-1] >= prio) begin
               held_elem[pos] = held_elem[pos-1];
               held_prio[pos] = held_prio[pos-1];
               pos--;
            end
            held_elem[pos] = elem;
            held_prio[pos] = prio;
            held_count++;
            if (held_count > peak_count) peak_count = held_count;
         end
      end else begin
         n_delete++;
         if (held_count == 0) begin
            r.status  = ST_UNDERFLOW;
            r.element = -1;
            r.prio    = -1;
            n_underflow++;
         end else begin
            r.element = held_elem[0];
            r.prio    = held_prio[0];
            for (int k = 1; k < held_count; k++) begin
               held_elem[k-1] = held_elem[k];
               held_prio[k-1] = held_prio[k];
            end
            held_count--;
         end
      end
      r.count = held_count[4:0];
      return r;
   endfunction

   // present one beat, optionally after random idle cycles, and record
   // its expected response once the block takes it
   task automatic send_beat(input logic cmd,
                            input logic signed [31:0] elem,
                            input logic signed [31:0] prio);
      while ($urandom_range(99) < idle_pct) begin
         // idle cycle with junk on the request fields
         start           <= 1'b0;
         req_cmd         <= 1'($urandom_range(1));
         req_element_in  <= $urandom;
         req_priority_in <= $urandom;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_element_in  <= elem;
      req_priority_in <= prio;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(apply_queue_beat(cmd, elem, prio));
   endtask

   // hold the sender off until every owed response has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // priorities: a tight cluster to force ties, the extremes, or anything
   function automatic logic signed [31:0] pick_prio();
      case ($urandom_range(3))
         0: return int'($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return -1;
               default: return 0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_elem();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // underflow on the empty queue, extreme fields, ties, back to empty
   task automatic test_directed_extremes();
      idle_pct = 0;
      send_beat(CMD_DELETE, 32'sh1234_5678, 32'sh7fff_ffff);   // delete on empty
      send_beat(CMD_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_beat(CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000);
      send_beat(CMD_INSERT, 32'sh0000_0000, 32'sh0000_0000);
      send_beat(CMD_INSERT, -1, 32'sh0000_0000);                // tie, goes ahead
      send_beat(CMD_INSERT, 32'sh5555_5555, 32'sh7fff_ffff);    // tie at the rear
      send_beat(CMD_INSERT, 32'shaaaa_aaaa, -1);
      for (int i = 0; i < 6; i++) send_beat(CMD_DELETE, $urandom, $urandom);
      send_beat(CMD_DELETE, -1, -1);                            // empty again
      wait_drained();
   endtask

   // fill past full to hit overflow, reuse a freed slot, drain past empty
   task automatic test_fill_and_drain();
      idle_pct = 0;
      for (int i = 0; i < DEPTH + 2; i++) send_beat(CMD_INSERT, pick_elem(), pick_prio());
      send_beat(CMD_DELETE, $urandom, $urandom);
      send_beat(CMD_INSERT, pick_elem(), pick_prio());          // freed slot taken again
      send_beat(CMD_INSERT, pick_elem(), pick_prio());          // refused, full once more
      for (int i = 0; i < DEPTH + 2; i++) send_beat(CMD_DELETE, $urandom, $urandom);
      wait_drained();
   endtask

   // random segments leaning toward fill, drain or balance so the queue
   // swings between empty and full at the given idle rate
   task automatic test_random_traffic(input int pct, input int n_items);
      int left;
      int seg;
      int bias;
      idle_pct = pct;
      left = n_items;
      while (left > 0) begin
         seg = $urandom_range(40, 8);
         case ($urandom_range(2))
            0: bias = 85;
            1: bias = 15;
            default: bias = 50;
         endcase
         for (int i = 0; i < seg && left > 0; i++) begin
            send_beat(($urandom_range(99) < bias) ? CMD_INSERT : CMD_DELETE,
                      pick_elem(), pick_prio());
            left--;
         end
         // now and then let everything settle before going on
         if ($urandom_range(9) == 0) wait_drained();
      end
      wait_drained();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                  input logic [31:0] got_v);
      $display("%0t mismatch on %s: expected %0d (0x%h), got %0d (0x%h)",
               $time, what, $signed(want_v), want_v, $signed(got_v), got_v);
      errors++;
   endtask

   // response checker and run watchdog; outputs sampled at the clock edge
   always @(posedge clock) begin
      queue_result_type want;
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t response beat with none expected: status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_element_out !== want.element)
               report_mismatch("element", want.element, rsp_element_out);
            if (rsp_priority_out !== want.prio)
               report_mismatch("priority", want.prio, rsp_priority_out);
            if (rsp_entry_count !== want.count)
               report_mismatch("entry count", 32'(want.count), 32'(rsp_entry_count));
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_fill_and_drain();
      test_random_traffic(0, 400);
      test_random_traffic(76, 400);
      test_random_traffic(7, 400);
      test_random_traffic(0, 350);

      // all beats answered; watch the tail for stray responses
      start <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d inserts (%0d refused when full) and %0d deletes (%0d on empty)",
               n_insert, n_overflow, n_delete, n_underflow);
      $display("%0d responses checked, peak depth %0d of %0d, sender idle 0/7/76 percent",
               n_checked, peak_count, DEPTH);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
